### design/sip_noninvite_server_transaction_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the non-INVITE server transaction
// Each macro writes one labeled concurrent assertion with reset qualification.
// ---------------------------------------------------------------------------
`ifndef SIP_NONINVITE_SERVER_TRANSACTION_ASSERT_SVH
`define SIP_NONINVITE_SERVER_TRANSACTION_ASSERT_SVH

// Same-cycle implication
`define SNST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("snst assertion failed: same-cycle implication");

// Next-cycle implication
`define SNST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("snst assertion failed: next-cycle implication");

`endif

### design/snst_pkg.sv
// ---------------------------------------------------------------------------
// snst_pkg
// Types, widths and codes shared by the non-INVITE server transaction.
// ---------------------------------------------------------------------------
`default_nettype none

package snst_pkg;

    // Field widths
    localparam int KIND_W     = 2;
    localparam int CODE_W     = 10;
    localparam int STATE_W    = 3;
    localparam int T1_W       = 12;
    localparam int TIMER_W    = 18;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 12;

    // Timer J is this many T1 intervals on an unreliable transport
    localparam int TIMER_J_FACTOR = 64;

    // Final responses start at this code
    localparam logic [CODE_W-1:0] FINAL_CODE = CODE_W'(200);

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_T1_TICKS = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_RELIABLE = CFG_ADDR_W'(1);

    // Configuration reset values
    localparam logic [T1_W-1:0] T1_TICKS_RESET = T1_W'(500);

    typedef enum logic [KIND_W-1:0] {
        KIND_START    = 2'd0,
        KIND_RESPONSE = 2'd1,
        KIND_RETRANS  = 2'd2,
        KIND_TICK     = 2'd3
    } t_kind;

    typedef enum logic [STATE_W-1:0] {
        PH_IDLE       = 3'd0,
        PH_TRYING     = 3'd1,
        PH_PROCEEDING = 3'd2,
        PH_COMPLETED  = 3'd3,
        PH_TERMINATED = 3'd4
    } t_phase;

    typedef struct packed {
        logic [T1_W-1:0] t1_ticks;
        logic            reliable;
    } t_cfg;

    typedef struct packed {
        logic [STATE_W-1:0] txn_state;
        logic               send_valid;
        logic [CODE_W-1:0]  send_code;
        logic               rejected;
        logic               timer_expired;
    } t_result;

endpackage

`default_nettype wire

### design/snst_if.sv
// ---------------------------------------------------------------------------
// snst channel interfaces
// Event, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

interface snst_evt_if;
    logic                           valid;
    logic                           ready;
    logic [snst_pkg::KIND_W-1:0]    kind;
    logic [snst_pkg::CODE_W-1:0]    status_code;

    modport source (output valid, output kind, output status_code, input ready);
    modport sink (input valid, input kind, input status_code, output ready);
endinterface

interface snst_res_if;
    logic                           valid;
    logic                           ready;
    logic [snst_pkg::STATE_W-1:0]   txn_state;
    logic                           send_valid;
    logic [snst_pkg::CODE_W-1:0]    send_code;
    logic                           rejected;
    logic                           timer_expired;

    modport source (
        output valid, output txn_state, output send_valid, output send_code,
        output rejected, output timer_expired, input ready
    );
    modport sink (
        input valid, input txn_state, input send_valid, input send_code,
        input rejected, input timer_expired, output ready
    );
endinterface

interface snst_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [snst_pkg::CFG_ADDR_W-1:0]  addr;
    logic [snst_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

### design/snst_core.sv
// ---------------------------------------------------------------------------
// snst_core
// Transaction state and timer J; applies one event per cycle when fired.
// ---------------------------------------------------------------------------
`default_nettype none

module snst_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_fire,
    input  snst_pkg::t_kind                  i_kind,
    input  wire  [snst_pkg::CODE_W-1:0]      i_code,
    input  snst_pkg::t_cfg                   i_cfg,
    output snst_pkg::t_result                o_result
);

    snst_pkg::t_phase                  r_phase, n_phase;
    logic [snst_pkg::CODE_W-1:0]       r_kept, n_kept;
    logic [snst_pkg::TIMER_W-1:0]      r_left, n_left;
    logic                              r_armed, n_armed;
    logic [snst_pkg::TIMER_W-1:0]      w_load;

    // Timer J load: T1 times the factor, zero on a reliable transport
    assign w_load = i_cfg.reliable ? '0
                  : snst_pkg::TIMER_W'(i_cfg.t1_ticks)
                    * snst_pkg::TIMER_W'(snst_pkg::TIMER_J_FACTOR);

    // Hold state between events
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= snst_pkg::PH_IDLE;
            r_kept  <= '0;
            r_left  <= '0;
            r_armed <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_kept  <= n_kept;
            r_left  <= n_left;
            r_armed <= n_armed;
        end
    end

    // Next state and result for the current event
    always_comb begin
        n_phase  = r_phase;
        n_kept   = r_kept;
        n_left   = r_left;
        n_armed  = r_armed;
        o_result = '0;

        unique case (i_kind)
            snst_pkg::KIND_START: begin
                n_phase = snst_pkg::PH_TRYING;
                n_kept  = '0;
                n_left  = '0;
                n_armed = 1'b0;
            end
            snst_pkg::KIND_RESPONSE: begin
                if (r_phase == snst_pkg::PH_TRYING || r_phase == snst_pkg::PH_PROCEEDING) begin
                    n_kept              = i_code;
                    o_result.send_valid = 1'b1;
                    o_result.send_code  = i_code;
                    if (i_code < snst_pkg::FINAL_CODE) begin
                        n_phase = snst_pkg::PH_PROCEEDING;
                    end else begin
                        n_phase = snst_pkg::PH_COMPLETED;
                        n_left  = w_load;
                        n_armed = 1'b1;
                    end
                end else if (r_phase == snst_pkg::PH_COMPLETED) begin
                    o_result.rejected = 1'b1;
                end
            end
            snst_pkg::KIND_RETRANS: begin
                if (r_phase == snst_pkg::PH_PROCEEDING || r_phase == snst_pkg::PH_COMPLETED) begin
                    o_result.send_valid = 1'b1;
                    o_result.send_code  = r_kept;
                end
            end
            snst_pkg::KIND_TICK: begin
                if (r_phase == snst_pkg::PH_COMPLETED && r_armed) begin
                    // Fire at one or zero, otherwise count down
                    if (r_left <= snst_pkg::TIMER_W'(1)) begin
                        n_left                 = '0;
                        n_armed                = 1'b0;
                        n_phase                = snst_pkg::PH_TERMINATED;
                        o_result.timer_expired = 1'b1;
                    end else begin
                        n_left = r_left - snst_pkg::TIMER_W'(1);
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        o_result.txn_state = n_phase;
    end

endmodule

`default_nettype wire

### design/sip_noninvite_server_transaction.sv
// ---------------------------------------------------------------------------
// sip_noninvite_server_transaction
// Non-INVITE server transaction engine with timer J and register access.
// ---------------------------------------------------------------------------
// Usage:
//   i_evt carries one event per item: kind (start, response, request
//   retransmission, tick) and a status code used by responses.
//   o_res returns exactly one result item per event: the state after the
//   event, the response sent (if any), a rejection flag and a timer J flag.
//   i_cfg writes T1 (index 0) and the reliable-transport flag (index 1);
//   it is always ready, and other indexes are dropped.
// Data path and throughput:
//   An event is captured in the input register, then processed and
//   written to the result register once that register is free or its
//   item is taken. One event per cycle is sustained while o_res is ready.
// Reset:
//   Synchronous, active low. The transaction goes idle, timer J disarms,
//   T1 returns to 500 and the transport is unreliable.
// Stall:
//   While o_res is held, the input register still takes one more event,
//   then i_evt.ready drops until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module sip_noninvite_server_transaction (
    input  wire          i_clk,
    input  wire          i_rst_n,
    snst_evt_if.sink     i_evt,
    snst_res_if.source   o_res,
    snst_cfg_if.sink     i_cfg
);

    logic                              r_evt_valid;
    logic [snst_pkg::KIND_W-1:0]       r_kind;
    logic [snst_pkg::CODE_W-1:0]       r_code;
    logic                              r_res_valid;
    snst_pkg::t_result                 r_res;
    snst_pkg::t_result                 w_result;
    snst_pkg::t_cfg                    r_cfg;
    logic                              w_adv;

    // Advance when an event waits and the result register is free
    assign w_adv       = r_evt_valid && (!r_res_valid || o_res.ready);
    assign i_evt.ready = !r_evt_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.t1_ticks <= snst_pkg::T1_TICKS_RESET;
            r_cfg.reliable <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                snst_pkg::CFG_T1_TICKS: r_cfg.t1_ticks <= i_cfg.data[snst_pkg::T1_W-1:0];
                snst_pkg::CFG_RELIABLE: r_cfg.reliable <= i_cfg.data[0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_valid <= 1'b0;
        end else if (i_evt.valid && i_evt.ready) begin
            r_evt_valid <= 1'b1;
        end else if (w_adv) begin
            r_evt_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_kind <= i_evt.kind;
            r_code <= i_evt.status_code;
        end
    end

    snst_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_adv),
        .i_kind   (snst_pkg::t_kind'(r_kind)),
        .i_code   (r_code),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_adv) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_result;
        end
    end

    assign o_res.valid         = r_res_valid;
    assign o_res.txn_state     = r_res.txn_state;
    assign o_res.send_valid    = r_res.send_valid;
    assign o_res.send_code     = r_res.send_code;
    assign o_res.rejected      = r_res.rejected;
    assign o_res.timer_expired = r_res.timer_expired;

endmodule

`default_nettype wire

### design/snst_checker.sv
// ---------------------------------------------------------------------------
// snst_checker
// Port-level checks on result items of the server transaction.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sip_noninvite_server_transaction_assert.svh"

module snst_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_valid,
    input wire                              i_ready,
    input wire [snst_pkg::STATE_W-1:0]      i_txn_state,
    input wire                              i_send_valid,
    input wire [snst_pkg::CODE_W-1:0]       i_send_code,
    input wire                              i_rejected,
    input wire                              i_timer_expired
);

    // Hold a stalled result item
    `SNST_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_txn_state) && $stable(i_send_valid) && $stable(i_send_code) && $stable(i_rejected) && $stable(i_timer_expired))

    // No code goes out without a send
    `SNST_ASSERT_NOW(a_code_zero, i_clk, i_rst_n, i_valid && !i_send_valid, i_send_code == '0)

    // Expiry lands in terminated with nothing sent or refused
    `SNST_ASSERT_NOW(a_expire, i_clk, i_rst_n, i_valid && i_timer_expired, (i_txn_state == snst_pkg::PH_TERMINATED) && !i_send_valid && !i_rejected)

    // Refusal happens only in completed
    `SNST_ASSERT_NOW(a_reject, i_clk, i_rst_n, i_valid && i_rejected, (i_txn_state == snst_pkg::PH_COMPLETED) && !i_send_valid)

    // Sends leave the transaction proceeding or completed
    `SNST_ASSERT_NOW(a_send_state, i_clk, i_rst_n, i_valid && i_send_valid, (i_txn_state == snst_pkg::PH_PROCEEDING) || (i_txn_state == snst_pkg::PH_COMPLETED))

endmodule

bind sip_noninvite_server_transaction snst_checker u_snst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_txn_state     (o_res.txn_state),
    .i_send_valid    (o_res.send_valid),
    .i_send_code     (o_res.send_code),
    .i_rejected      (o_res.rejected),
    .i_timer_expired (o_res.timer_expired)
);

`default_nettype wire
